// ===== rtl/core/ptirs_pkg.sv =====
// ============================================================================
// ptirs_pkg
// Shared widths, command and status codes, and controller/datapath bundles
// for the ordered key/value pair table.
// ============================================================================
package ptirs_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int STS_W  = 3;
    localparam int FILL_W = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STS_W-1:0] ST_NOKEY = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        logic              load;
        op_t               op;
        logic              at_end;
        logic              scan_inc;
        logic              out_load;
        logic              rd_sel;
        logic [STS_W-1:0]  status;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              full;
        logic              empty;
        logic              pos_gt;
        logic              pos_ge;
        logic              hit;
        logic              last;
    } dp_sts_t;

endpackage

// ===== rtl/core/ptirs_req_if.sv =====
// ============================================================================
// ptirs_req_if
// Command channel: valid/ready handshake carrying one table command.
// ============================================================================
interface ptirs_req_if
    import ptirs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output position, output key,
                    output value, input ready);
    modport sink   (input valid, input command, input position, input key,
                    input value, output ready);
endinterface

// ===== rtl/core/ptirs_rsp_if.sv =====
// ============================================================================
// ptirs_rsp_if
// Response channel: valid/ready handshake carrying one command result.
// ============================================================================
interface ptirs_rsp_if
    import ptirs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STS_W-1:0]         status;
    logic [FILL_W-1:0]        fill_count;
    logic signed [DATA_W-1:0] read_key;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output status, output fill_count,
                    output read_key, output read_value, input ready);
    modport sink   (input valid, input status, input fill_count,
                    input read_key, input read_value, output ready);
endinterface

// ===== rtl/core/ptirs_datapath.sv =====
// ============================================================================
// ptirs_datapath
// Entry cells with neighbour shifting, command latch, key scan pointer,
// fill count and response register.
// ============================================================================
module ptirs_datapath
    import ptirs_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CMD_W-1:0]         command,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    input  ctl_t                     ctl,
    output dp_sts_t                  sts,
    output logic [STS_W-1:0]         status,
    output logic [FILL_W-1:0]        fill_count,
    output logic signed [DATA_W-1:0] read_key,
    output logic signed [DATA_W-1:0] read_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CMD_W-1:0]         cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] keys_reg [CAPACITY];
    logic signed [DATA_W-1:0] vals_reg [CAPACITY];
    logic signed [DATA_W-1:0] lo_key   [CAPACITY];
    logic signed [DATA_W-1:0] lo_val   [CAPACITY];
    logic signed [DATA_W-1:0] hi_key   [CAPACITY];
    logic signed [DATA_W-1:0] hi_val   [CAPACITY];
    logic [STS_W-1:0]         status_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic signed [DATA_W-1:0] rk_reg;
    logic signed [DATA_W-1:0] rv_reg;

    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         cnt_x;
    logic [CMP_W-1:0]         ins_pos;
    logic [IDX_W-1:0]         rd_idx;

    assign pos_x   = CMP_W'(pos_reg);
    assign cnt_x   = CMP_W'(cnt_reg);
    assign ins_pos = ctl.at_end ? cnt_x : pos_x;
    assign rd_idx  = pos_x[IDX_W-1:0];

    assign sts.command = cmd_reg;
    assign sts.full    = (cnt_reg == CNT_W'(CAPACITY));
    assign sts.empty   = (cnt_reg == '0);
    assign sts.pos_gt  = (pos_x > cnt_x);
    assign sts.pos_ge  = (pos_x >= cnt_x);
    assign sts.hit     = (keys_reg[idx_reg] == key_reg);
    assign sts.last    = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(cnt_reg);

    always_comb
    begin
        case (ctl.op)
            OP_INSERT: cnt_next = cnt_reg + CNT_W'(1);
            OP_REMOVE: cnt_next = cnt_reg - CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            key_reg <= key;
            val_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctl.load)
                idx_reg <= '0;
            else if (ctl.scan_inc)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i > 0)
        begin : g_lo
            assign lo_key[i] = keys_reg[i-1];
            assign lo_val[i] = vals_reg[i-1];
        end
        else
        begin : g_lo0
            assign lo_key[i] = keys_reg[i];
            assign lo_val[i] = vals_reg[i];
        end

        if (i < CAPACITY - 1)
        begin : g_hi
            assign hi_key[i] = keys_reg[i+1];
            assign hi_val[i] = vals_reg[i+1];
        end
        else
        begin : g_hi_top
            assign hi_key[i] = keys_reg[i];
            assign hi_val[i] = vals_reg[i];
        end

        always_ff @(posedge clk)
        begin
            case (ctl.op)
                OP_INSERT:
                begin
                    if (CMP_W'(i) == ins_pos)
                    begin
                        keys_reg[i] <= key_reg;
                        vals_reg[i] <= val_reg;
                    end
                    else if (CMP_W'(i) > ins_pos && CMP_W'(i) <= cnt_x)
                    begin
                        keys_reg[i] <= lo_key[i];
                        vals_reg[i] <= lo_val[i];
                    end
                end
                OP_REMOVE:
                begin
                    if (CMP_W'(i) >= pos_x && CMP_W'(i + 1) < cnt_x)
                    begin
                        keys_reg[i] <= hi_key[i];
                        vals_reg[i] <= hi_val[i];
                    end
                end
                OP_UPDATE:
                begin
                    if (IDX_W'(i) == idx_reg)
                        vals_reg[i] <= val_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            status_reg <= ctl.status;
            fill_reg   <= FILL_W'(cnt_next);
            rk_reg     <= ctl.rd_sel ? keys_reg[rd_idx] : '0;
            rv_reg     <= ctl.rd_sel ? vals_reg[rd_idx] : '0;
        end
    end

    assign status     = status_reg;
    assign fill_count = fill_reg;
    assign read_key   = rk_reg;
    assign read_value = rv_reg;

endmodule

// ===== rtl/core/ptirs_ctrl.sv =====
// ============================================================================
// ptirs_ctrl
// Command sequencer: accepts a transaction, checks it, drives the datapath
// operation, steps the key scan and manages the response handshake.
// ============================================================================
module ptirs_ctrl
    import ptirs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  dp_sts_t sts,
    output ctl_t    ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.op       = OP_NONE;
        ctl.status   = ST_OK;
        ctl.load     = req_valid && req_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                    unique case (sts.command)
                        CMD_APPEND:
                        begin
                            if (sts.full)
                                ctl.status = ST_FULL;
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                ctl.at_end = 1'b1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (sts.full)
                                ctl.status = ST_FULL;
                            else if (sts.pos_gt)
                                ctl.status = ST_RANGE;
                            else
                                ctl.op = OP_INSERT;
                        end
                        CMD_REMOVE:
                        begin
                            if (sts.empty)
                                ctl.status = ST_EMPTY;
                            else if (sts.pos_ge)
                                ctl.status = ST_RANGE;
                            else
                                ctl.op = OP_REMOVE;
                        end
                        CMD_UPDATE:
                        begin
                            if (sts.empty)
                                ctl.status = ST_NOKEY;
                            else
                            begin
                                ctl.out_load = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_READ:
                        begin
                            if (sts.empty)
                                ctl.status = ST_EMPTY;
                            else if (sts.pos_ge)
                                ctl.status = ST_RANGE;
                            else
                                ctl.rd_sel = 1'b1;
                        end
                        default:
                        begin
                            ctl.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    if (out_free)
                    begin
                        ctl.out_load = 1'b1;
                        state_next   = S_IDLE;
                        if (sts.hit)
                            ctl.op = OP_UPDATE;
                        else
                            ctl.status = ST_NOKEY;
                    end
                end
                else
                    ctl.scan_inc = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

endmodule

// ===== rtl/core/pair_table_insert_remove_shift_core.sv =====
// ============================================================================
// pair_table_insert_remove_shift_core
// Fixed-capacity ordered key/value table with append, positional insert and
// remove, update by key and positional read; one response per transaction.
// ----------------------------------------------------------------------------
// Sequence: acceptance latches the command; the sequencer then checks it and
//   loads the registered response. Update by key first steps the key scan one
//   entry per cycle to the matching position (or fill count - 1 on a miss).
// Flow: one transaction at a time, accepted only while the sequencer is idle.
//   The response register lets the next transaction in while a result waits.
// Reset: asynchronous, active low; clears fill count, key scan pointer,
//   sequencer and response valid. Entry contents are not reset.
// ============================================================================
module pair_table_insert_remove_shift_core
    import ptirs_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptirs_req_if.sink   req,
    ptirs_rsp_if.source rsp
);

    ctl_t    ctl;
    dp_sts_t sts;

    ptirs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    ptirs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (req.command),
        .position   (req.position),
        .key        (req.key),
        .value      (req.value),
        .ctl        (ctl),
        .sts        (sts),
        .status     (rsp.status),
        .fill_count (rsp.fill_count),
        .read_key   (rsp.read_key),
        .read_value (rsp.read_value)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("transaction accepted while another is in progress");

    a_no_overwrite_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!rsp.valid || rsp.ready))
        else $error("response register loaded while holding a result");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_INSERT) |-> !sts.full)
        else $error("insert issued on a full table");

    a_remove_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_REMOVE) |-> !sts.empty)
        else $error("remove issued on an empty table");

endmodule
